// ===== rtl/tss_pkg.sv =====
`timescale 1ns / 1ps
// Package for the timed step sequencer: shared types, codes and constants.
// Also holds the fixed-point helpers for the clock update. No dependencies.
package tss_pkg;

  localparam logic [31:0] Q24_ONE    = 32'h0100_0000;
  localparam logic [31:0] Q24_SIXTY  = 32'h3C00_0000;
  localparam logic [31:0] WHOLE_MASK = 32'hFF00_0000;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    CFG_SAMPLE_TIME = 3'd0,
    CFG_STEP_COUNT  = 3'd1,
    CFG_PARAM_COUNT = 3'd2,
    CFG_TIME_UNIT   = 3'd3,
    CFG_DUR_FORMAT  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    TU_SECONDS = 2'd0,
    TU_MINUTES = 2'd1,
    TU_HOURS   = 2'd2,
    TU_ZERO    = 2'd3
  } time_unit_t;

  typedef enum logic [1:0] {
    RUN_ACTIVE  = 2'd0,
    RUN_HELD    = 2'd1,
    RUN_PENDING = 2'd2
  } run_flag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEC_ADD,
    ST_SEC_WRAP,
    ST_MIN_INC,
    ST_MIN_FRAC,
    ST_MIN_WRAP,
    ST_HR_INC,
    ST_HR_FRAC,
    ST_HR_SEC,
    ST_TGT_ADD,
    ST_CMP,
    ST_EMIT_ADDR,
    ST_EMIT
  } tss_state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        ge;
  } alu_rsp_t;

  // Truncating division of the signed whole part of a Q24 word by 60.
  // 2^24 / 60 = 279620 + 4/15; floor(x / 15) = (x * 4370) >> 16 for x <= 512.
  function automatic logic [31:0] div60_whole(logic [7:0] w);
    logic [8:0]  m;
    logic [31:0] q;
    logic [31:0] fr;
    m  = w[7] ? (9'd0 - {w[7], w}) : {1'b0, w};
    fr = (32'({m, 2'b00}) * 32'd4370) >> 16;
    q  = 32'(m) * 32'd279620 + fr;
    return w[7] ? (32'd0 - q) : q;
  endfunction

  // Truncating division by 3600: 2^24 / 3600 = 4660 + 76/225.
  // floor(y / 225) = (y * 74566) >> 24 for y <= 9728.
  function automatic logic [31:0] div3600_whole(logic [7:0] w);
    logic [8:0]  m;
    logic [31:0] q;
    logic [31:0] fr;
    m  = w[7] ? (9'd0 - {w[7], w}) : {1'b0, w};
    fr = (32'(m) * 32'd76 * 32'd74566) >> 24;
    q  = 32'(m) * 32'd4660 + fr;
    return w[7] ? (32'd0 - q) : q;
  endfunction

  // Brings a stored duration from Q(fmt) to Q24.
  function automatic logic [31:0] scale_dur(logic [31:0] d, logic [4:0] fmt);
    logic [4:0] sh;
    logic [31:0] r;
    if (fmt > 5'd24) begin
      sh = fmt - 5'd24;
      r  = 32'($signed(d) >>> sh);
    end else begin
      sh = 5'd24 - fmt;
      r  = d << sh;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tss_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the timed step sequencer: input, result and config.
// Depends on tss_pkg for the config index width.
interface tss_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [4:0]         force_step;
  logic               restart;
  logic               stop_mode;
  logic [7:0]         table_address;
  logic signed [31:0] table_word;

  modport source (output valid, kind, force_step, restart, stop_mode, table_address,
                  table_word, input ready);
  modport sink (input valid, kind, force_step, restart, stop_mode, table_address,
                table_word, output ready);
endinterface

interface tss_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         step_index;
  logic [2:0]         param_index;
  logic signed [31:0] param_value;
  logic               last;

  modport source (output valid, step_index, param_index, param_value, last, input ready);
  modport sink (input valid, step_index, param_index, param_value, last, output ready);
endinterface

interface tss_cfg_if import tss_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/timed_step_sequencer.sv =====
`timescale 1ns / 1ps
// A table write word is taken only while idle. A tick that advances the clocks steps
// through one shared 33-bit adder, which updates seconds, minutes and hours, forms the step
// deadline and compares it, then streams out the parameter words of the step while the
// result side takes words. A held, forced or restarting tick skips the clock update and
// goes straight to the parameter words. The step table has one write port and a registered
// read port, so words stream out at one per cycle while the result side takes them.
module timed_step_sequencer import tss_pkg::*; #(
  parameter int MAX_STEPS  = 16,
  parameter int MAX_PARAMS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  tss_in_if.sink         in_port,
  tss_out_if.source      out_port,
  tss_cfg_if.sink        cfg_port
);

  localparam int TABLE_WORDS = MAX_STEPS * (MAX_PARAMS + 1);
  localparam int ADDR_W      = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
  localparam int STEP_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int SCW         = ($clog2(MAX_STEPS + 1) > 5) ? $clog2(MAX_STEPS + 1) : 5;
  localparam int PCW         = ($clog2(MAX_PARAMS + 1) > 4) ? $clog2(MAX_PARAMS + 1) : 4;
  localparam int MW          = STEP_W + PCW + 1;

  tss_state_t         state_r, state_nxt;
  run_flag_t          run_r, run_nxt;
  logic [STEP_W-1:0]  cur_r, cur_nxt;
  logic [31:0]        sec_r, sec_nxt;
  logic [31:0]        min_r, min_nxt;
  logic [31:0]        hr_r, hr_nxt;
  logic [31:0]        dl_r, dl_nxt;
  logic [31:0]        target_r, target_nxt;
  logic               carry_r, carry_nxt;
  logic               mode_r, mode_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [PCW-1:0]     idx_r, idx_nxt;
  logic [31:0]        rdata_r;
  logic [ADDR_W-1:0]  rd_addr;

  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_step_r;
  logic [2:0]         out_pidx_r;
  logic [31:0]        out_value_r;
  logic               out_last_r;
  logic               out_load;

  logic [30:0]        sample_time_r;
  logic [4:0]         step_count_r;
  logic [3:0]         param_count_r;
  logic [1:0]         time_unit_r;
  logic [4:0]         dur_fmt_r;

  logic [31:0]        table_mem [TABLE_WORDS];

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  logic               in_acc;
  logic               is_write;
  logic               force_ok;
  logic [SCW-1:0]     eff_steps;
  logic [PCW-1:0]     pc_eff;
  logic [PCW:0]       pc_stride;
  logic [MW-1:0]      dur_base;
  logic [SCW-1:0]     step_inc;
  logic               slot_free;
  logic               last_word;
  logic [31:0]        timer;

  tss_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_port.ready  = (state_r == ST_IDLE);
  assign cfg_port.ready = 1'b1;
  assign in_acc         = in_port.valid && in_port.ready;
  assign is_write       = (in_port.kind == KIND_WRITE);

  assign eff_steps = (SCW'(step_count_r) > SCW'(MAX_STEPS)) ? SCW'(MAX_STEPS)
                                                             : SCW'(step_count_r);
  assign pc_eff    = (PCW'(param_count_r) > PCW'(MAX_PARAMS)) ? PCW'(MAX_PARAMS)
                                                               : PCW'(param_count_r);
  assign pc_stride = (PCW + 1)'(pc_eff) + 1'b1;
  assign dur_base  = MW'(cur_r) * MW'(pc_stride);
  assign force_ok  = (SCW'(in_port.force_step) <= eff_steps);
  assign step_inc  = SCW'(cur_r) + 1'b1;
  assign slot_free = !out_valid_r || out_port.ready;
  assign last_word = ((idx_r + 1'b1) == pc_eff);

  always_comb begin
    case (time_unit_r)
      TU_SECONDS: timer = sec_r;
      TU_MINUTES: timer = min_r;
      TU_HOURS:   timer = hr_r;
      default:    timer = 32'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !is_write) begin
          if (in_port.force_step != 5'd0) begin
            if (force_ok && pc_eff != '0) begin
              state_nxt = ST_EMIT_ADDR;
            end
          end else if (!in_port.restart && run_r == RUN_ACTIVE) begin
            state_nxt = ST_SEC_ADD;
          end else if (pc_eff != '0) begin
            state_nxt = ST_EMIT_ADDR;
          end
        end
      end
      ST_SEC_ADD:  state_nxt = ST_SEC_WRAP;
      ST_SEC_WRAP: state_nxt = ST_MIN_INC;
      ST_MIN_INC:  state_nxt = ST_MIN_FRAC;
      ST_MIN_FRAC: state_nxt = ST_MIN_WRAP;
      ST_MIN_WRAP: state_nxt = ST_HR_INC;
      ST_HR_INC:   state_nxt = ST_HR_FRAC;
      ST_HR_FRAC:  state_nxt = ST_HR_SEC;
      ST_HR_SEC:   state_nxt = ST_TGT_ADD;
      ST_TGT_ADD:  state_nxt = ST_CMP;
      ST_CMP:      state_nxt = (pc_eff != '0) ? ST_EMIT_ADDR : ST_IDLE;
      ST_EMIT_ADDR: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free && last_word) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    run_nxt    = run_r;
    cur_nxt    = cur_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hr_nxt     = hr_r;
    dl_nxt     = dl_r;
    target_nxt = target_r;
    carry_nxt  = carry_r;
    mode_nxt   = mode_r;
    addr_nxt   = addr_r;
    idx_nxt    = idx_r;
    rd_addr    = addr_r;
    out_load   = 1'b0;
    alu_req    = '{a: sec_r, b: 32'd0, sub: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !is_write) begin
          mode_nxt = in_port.stop_mode;
          if (in_port.force_step != 5'd0) begin
            if (force_ok) begin
              cur_nxt = STEP_W'(in_port.force_step - 5'd1);
              run_nxt = in_port.stop_mode ? RUN_PENDING : RUN_HELD;
            end
          end else if (in_port.restart || run_r == RUN_PENDING) begin
            cur_nxt = '0;
            sec_nxt = 32'd0;
            min_nxt = 32'd0;
            hr_nxt  = 32'd0;
            dl_nxt  = 32'd0;
            run_nxt = RUN_ACTIVE;
          end
        end
      end
      ST_SEC_ADD: begin
        alu_req = '{a: sec_r, b: {1'b0, sample_time_r}, sub: 1'b0};
        sec_nxt = alu_rsp.sum;
      end
      ST_SEC_WRAP: begin
        alu_req   = '{a: sec_r, b: Q24_SIXTY, sub: 1'b1};
        carry_nxt = alu_rsp.ge;
        if (alu_rsp.ge) begin
          sec_nxt = alu_rsp.sum;
        end
      end
      ST_MIN_INC: begin
        alu_req = '{a: min_r, b: (carry_r ? Q24_ONE : 32'd0), sub: 1'b0};
        min_nxt = alu_rsp.sum;
      end
      ST_MIN_FRAC: begin
        alu_req = '{a: min_r & WHOLE_MASK, b: div60_whole(sec_r[31:24]), sub: 1'b0};
        min_nxt = alu_rsp.sum;
      end
      ST_MIN_WRAP: begin
        alu_req   = '{a: min_r, b: Q24_SIXTY, sub: 1'b1};
        carry_nxt = alu_rsp.ge;
        if (alu_rsp.ge) begin
          min_nxt = alu_rsp.sum;
        end
      end
      ST_HR_INC: begin
        alu_req = '{a: hr_r, b: (carry_r ? Q24_ONE : 32'd0), sub: 1'b0};
        hr_nxt  = alu_rsp.sum;
      end
      ST_HR_FRAC: begin
        alu_req = '{a: hr_r & WHOLE_MASK, b: div60_whole(min_r[31:24]), sub: 1'b0};
        hr_nxt  = alu_rsp.sum;
      end
      ST_HR_SEC: begin
        alu_req = '{a: hr_r, b: div3600_whole(sec_r[31:24]), sub: 1'b0};
        hr_nxt  = alu_rsp.sum;
        rd_addr = ADDR_W'(dur_base);
      end
      ST_TGT_ADD: begin
        alu_req    = '{a: dl_r, b: scale_dur(rdata_r, dur_fmt_r), sub: 1'b0};
        target_nxt = alu_rsp.sum;
      end
      ST_CMP: begin
        alu_req = '{a: timer, b: target_r, sub: 1'b1};
        if (alu_rsp.ge) begin
          dl_nxt = target_r;
          if (step_inc >= eff_steps) begin
            cur_nxt = '0;
            run_nxt = mode_r ? RUN_PENDING : RUN_HELD;
          end else begin
            cur_nxt = STEP_W'(step_inc);
          end
        end
      end
      ST_EMIT_ADDR: begin
        rd_addr  = ADDR_W'(dur_base + 1'b1);
        addr_nxt = ADDR_W'(dur_base + 1'b1);
        idx_nxt  = '0;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (!last_word) begin
            idx_nxt  = idx_r + 1'b1;
            addr_nxt = addr_r + 1'b1;
            rd_addr  = addr_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_port.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_r       <= RUN_ACTIVE;
      cur_r       <= '0;
      sec_r       <= 32'd0;
      min_r       <= 32'd0;
      hr_r        <= 32'd0;
      dl_r        <= 32'd0;
      carry_r     <= 1'b0;
      mode_r      <= 1'b0;
      idx_r       <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_r       <= run_nxt;
      cur_r       <= cur_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hr_r        <= hr_nxt;
      dl_r        <= dl_nxt;
      carry_r     <= carry_nxt;
      mode_r      <= mode_nxt;
      idx_r       <= idx_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    if (out_load) begin
      out_step_r  <= 4'(cur_r);
      out_pidx_r  <= 3'(idx_r);
      out_value_r <= rdata_r;
      out_last_r  <= last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_write && (32'(in_port.table_address) < 32'(TABLE_WORDS))) begin
      table_mem[ADDR_W'(in_port.table_address)] <= in_port.table_word;
    end
    rdata_r <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_time_r <= 31'd0;
      step_count_r  <= 5'd1;
      param_count_r <= 4'd0;
      time_unit_r   <= TU_SECONDS;
      dur_fmt_r     <= 5'd24;
    end else if (cfg_port.valid && cfg_port.ready) begin
      case (cfg_port.index)
        CFG_SAMPLE_TIME: sample_time_r <= cfg_port.data[30:0];
        CFG_STEP_COUNT:  step_count_r  <= cfg_port.data[4:0];
        CFG_PARAM_COUNT: param_count_r <= cfg_port.data[3:0];
        CFG_TIME_UNIT:   time_unit_r   <= cfg_port.data[1:0];
        CFG_DUR_FORMAT:  dur_fmt_r     <= cfg_port.data[4:0];
        default: begin
        end
      endcase
    end
  end

  assign out_port.valid       = out_valid_r;
  assign out_port.step_index  = out_step_r;
  assign out_port.param_index = out_pidx_r;
  assign out_port.param_value = out_value_r;
  assign out_port.last        = out_last_r;

  a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result word appeared outside the emit state");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r < pc_eff))
    else $error("parameter index ran past the parameter count");

  a_step_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_step_r == 4'($past(cur_r))) && (out_pidx_r == 3'($past(idx_r))))
    else $error("result word tagged with the wrong step or index");

  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_write && in_port.force_step == 5'd0 && !in_port.restart &&
     run_r == RUN_ACTIVE) |=> !in_port.ready)
    else $error("running tick did not start the clock update");

endmodule

// ===== rtl/tss_alu.sv =====
`timescale 1ns / 1ps
// Shared 33-bit add, subtract and signed compare unit of the sequencer.
// Depends on tss_pkg for the request and response structs.
module tss_alu import tss_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] a_ext;
  logic [32:0] b_ext;
  logic [32:0] res;

  assign a_ext   = {req.a[31], req.a};
  assign b_ext   = req.sub ? ~{req.b[31], req.b} : {req.b[31], req.b};
  assign res     = a_ext + b_ext + 33'(req.sub);
  assign rsp.sum = res[31:0];
  assign rsp.ge  = ~res[32];

endmodule
